// ===== hdl/polygon_separating_axis_collision_macros.svh =====
// Assertion macros shared by the checker of the polygon collision block.
`ifndef POLYGON_SEPARATING_AXIS_COLLISION_MACROS_SVH
`define POLYGON_SEPARATING_AXIS_COLLISION_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psac_pkg.sv =====
// Shared constants and types of the polygon separating axis collision block.
package psac_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_W          = 16;
    localparam int PUSH_W           = 32;
    localparam int QMAG_W           = 26;
    localparam int DIV_STEPS        = 32;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] ST_SEPARATED = 2'd0;
    localparam logic [1:0] ST_COLLIDING = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EDGE_PREV,
        S_EDGE_LATCH,
        S_EDGE_RD,
        S_EDGE_NORM,
        S_EDGE_SQ,
        S_EDGE_LEN,
        S_PROJ_RD,
        S_PROJ_MUL,
        S_PROJ_ACC,
        S_OVERLAP,
        S_SCALE_LO,
        S_SCALE_HI,
        S_SCALE_NUM,
        S_DIVIDE,
        S_QLEN_SQ,
        S_QLEN_SUM,
        S_FLIP_MUL,
        S_FLIP,
        S_DONE
    } state_t;

endpackage

// ===== hdl/polygon_separating_axis_collision.sv =====
// Load item: in_ready stays high, the vertex goes into the vertex memory of A or B.
// Compute item with na, nb vertices: one memory read per vertex per axis and a 32-step restoring
// divider per scaled component; in_ready stays low until the result is registered.
// The result waits in an output register; loads are taken while it waits.
// Reset clears vertex counts, the overflow flag, the state machine and out_valid;
// vertex memories are not cleared and only entries written since the last compute are read.
module polygon_separating_axis_collision
    import psac_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic signed [COORD_W-1:0]  x,
    input  logic signed [COORD_W-1:0]  y,
    input  logic signed [COORD_W-1:0]  ref_x,
    input  logic signed [COORD_W-1:0]  ref_y,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic signed [PUSH_W-1:0]   push_x,
    output logic signed [PUSH_W-1:0]   push_y
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = $clog2(DIV_STEPS);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VERTICES);
    localparam logic [DW-1:0] DIV_LAST  = DW'(DIV_STEPS - 1);

    state_t state_reg, state_next;

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic          ovf_reg, ovf_next;
    logic          out_valid_reg, out_valid_next;

    logic [2*COORD_W-1:0] mem_a [MAX_VERTICES];
    logic [2*COORD_W-1:0] mem_b [MAX_VERTICES];
    logic [2*COORD_W-1:0] qa_reg, qb_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_a, wr_b;

    logic                 phase_reg;
    logic                 span_sel_reg;
    logic                 comp_sel_reg;
    logic [CW-1:0]        edge_idx_reg;
    logic [CW-1:0]        vtx_idx_reg;
    logic [DW-1:0]        div_cnt_reg;

    logic signed [16:0]   dx_reg, dy_reg;
    logic signed [15:0]   prev_x_reg, prev_y_reg;
    logic signed [16:0]   nx_reg, ny_reg;
    logic [31:0]          sqx_reg, sqy_reg;
    logic [32:0]          len2_reg;
    logic signed [32:0]   prod_x_reg, prod_y_reg;
    logic signed [33:0]   lo_reg, hi_reg, a_lo_reg, a_hi_reg;
    logic [34:0]          d_reg;
    logic [33:0]          p_lo_reg;
    logic [32:0]          p_hi_reg;
    logic [32:0]          rem_reg;
    logic [31:0]          numlo_reg;
    logic [QMAG_W-1:0]    magx_reg, magy_reg;
    logic [2*QMAG_W-1:0]  sqqx_reg, sqqy_reg;
    logic signed [PUSH_W-1:0] bx_reg, by_reg;
    logic [2*QMAG_W:0]    blen_reg;
    logic                 have_reg;
    logic signed [48:0]   fx_reg, fy_reg;
    logic [1:0]           res_status_reg;
    logic [1:0]           status_reg;
    logic signed [PUSH_W-1:0] push_x_reg, push_y_reg;

    // Combinational datapath terms
    logic [CW-1:0]        edge_cnt;
    logic [CW-1:0]        edge_cnt_m1;
    logic [CW-1:0]        span_cnt;
    logic                 edge_last;
    logic                 vtx_last;
    logic [2*COORD_W-1:0] edge_q;
    logic [2*COORD_W-1:0] span_q;
    logic signed [15:0]   edge_vx, edge_vy, span_vx, span_vy;
    logic signed [33:0]   nx_sq, ny_sq;
    logic [32:0]          len_sum;
    logic signed [33:0]   proj;
    logic signed [33:0]   lo_new, hi_new;
    logic signed [34:0]   ov1, ov2;
    logic                 separated;
    logic signed [16:0]   comp;
    logic [16:0]          comp_abs;
    logic [50:0]          num;
    logic [33:0]          trial;
    logic                 q_bit;
    logic [33:0]          trial_sub;
    logic [31:0]          quo;
    logic [31:0]          quo_signed;
    logic [2*QMAG_W:0]    ql;
    logic                 keep;
    logic signed [49:0]   flip_sum;
    logic                 out_take;

    assign edge_cnt    = phase_reg ? count_b_reg : count_a_reg;
    assign edge_cnt_m1 = edge_cnt - CW'(1);
    assign span_cnt    = span_sel_reg ? count_b_reg : count_a_reg;
    assign edge_last   = (edge_idx_reg + CW'(1)) == edge_cnt;
    assign vtx_last    = (vtx_idx_reg + CW'(1)) == span_cnt;
    assign edge_q      = phase_reg ? qb_reg : qa_reg;
    assign span_q      = span_sel_reg ? qb_reg : qa_reg;
    assign edge_vx     = $signed(edge_q[2*COORD_W-1:COORD_W]);
    assign edge_vy     = $signed(edge_q[COORD_W-1:0]);
    assign span_vx     = $signed(span_q[2*COORD_W-1:COORD_W]);
    assign span_vy     = $signed(span_q[COORD_W-1:0]);
    assign nx_sq       = nx_reg * nx_reg;
    assign ny_sq       = ny_reg * ny_reg;
    assign len_sum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign proj   = 34'(prod_x_reg) + 34'(prod_y_reg);
    assign lo_new = (vtx_idx_reg == '0 || proj < lo_reg) ? proj : lo_reg;
    assign hi_new = (vtx_idx_reg == '0 || proj > hi_reg) ? proj : hi_reg;

    // lo_reg/hi_reg hold the span of B here
    assign ov1       = 35'(a_hi_reg) - 35'(lo_reg);
    assign ov2       = 35'(hi_reg) - 35'(a_lo_reg);
    assign separated = (a_hi_reg < lo_reg) || (hi_reg < a_lo_reg);

    assign comp     = comp_sel_reg ? ny_reg : nx_reg;
    assign comp_abs = comp[16] ? 17'(-comp) : 17'(comp);
    assign num      = {p_hi_reg, 18'b0} + {17'b0, p_lo_reg};

    assign trial      = {rem_reg, numlo_reg[31]};
    assign q_bit      = trial >= {1'b0, len2_reg};
    assign trial_sub  = trial - {1'b0, len2_reg};
    assign quo        = {numlo_reg[30:0], q_bit};
    assign quo_signed = comp[16] ? (32'd0 - quo) : quo;

    assign ql   = {1'b0, sqqx_reg} + {1'b0, sqqy_reg};
    assign keep = !have_reg || (ql < blen_reg);

    assign flip_sum = 50'(fx_reg) + 50'(fy_reg);
    assign out_take = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && command == CMD_COMPUTE)
                begin
                    if (ovf_reg || count_a_reg == '0 || count_b_reg == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_EDGE_PREV;
                end
            end
            S_EDGE_PREV:  state_next = S_EDGE_LATCH;
            S_EDGE_LATCH: state_next = S_EDGE_NORM;
            S_EDGE_RD:    state_next = S_EDGE_NORM;
            S_EDGE_NORM:  state_next = S_EDGE_SQ;
            S_EDGE_SQ:    state_next = S_EDGE_LEN;
            S_EDGE_LEN:
            begin
                if (len_sum != '0)
                    state_next = S_PROJ_RD;
                else if (!edge_last)
                    state_next = S_EDGE_RD;
                else if (!phase_reg)
                    state_next = S_EDGE_PREV;
                else
                    state_next = S_FLIP_MUL;
            end
            S_PROJ_RD:  state_next = S_PROJ_MUL;
            S_PROJ_MUL: state_next = S_PROJ_ACC;
            S_PROJ_ACC:
            begin
                if (!vtx_last || !span_sel_reg)
                    state_next = S_PROJ_RD;
                else
                    state_next = S_OVERLAP;
            end
            S_OVERLAP:   state_next = separated ? S_DONE : S_SCALE_LO;
            S_SCALE_LO:  state_next = S_SCALE_HI;
            S_SCALE_HI:  state_next = S_SCALE_NUM;
            S_SCALE_NUM: state_next = S_DIVIDE;
            S_DIVIDE:
            begin
                if (div_cnt_reg == DIV_LAST)
                    state_next = comp_sel_reg ? S_QLEN_SQ : S_SCALE_LO;
            end
            S_QLEN_SQ: state_next = S_QLEN_SUM;
            S_QLEN_SUM:
            begin
                if (!edge_last)
                    state_next = S_EDGE_RD;
                else if (!phase_reg)
                    state_next = S_EDGE_PREV;
                else
                    state_next = S_FLIP_MUL;
            end
            S_FLIP_MUL: state_next = S_FLIP;
            S_FLIP:     state_next = S_DONE;
            S_DONE:
            begin
                if (out_take)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Handshake and memory port control
    always_comb
    begin
        in_ready = 1'b0;
        wr_a     = 1'b0;
        wr_b     = 1'b0;
        rd_addr  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                wr_a = in_valid && command == CMD_LOAD_A && count_a_reg < MAX_COUNT;
                wr_b = in_valid && command == CMD_LOAD_B && count_b_reg < MAX_COUNT;
            end
            S_EDGE_PREV:              rd_addr = edge_cnt_m1[AW-1:0];
            S_EDGE_LATCH, S_EDGE_RD:  rd_addr = edge_idx_reg[AW-1:0];
            S_PROJ_RD:                rd_addr = vtx_idx_reg[AW-1:0];
            default:                  rd_addr = '0;
        endcase
    end

    // Vertex counts, overflow flag and output valid
    always_comb
    begin
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (wr_a)
            count_a_next = count_a_reg + CW'(1);
        if (wr_b)
            count_b_next = count_b_reg + CW'(1);
        if (in_ready && in_valid && !wr_a && command == CMD_LOAD_A)
            ovf_next = 1'b1;
        if (in_ready && in_valid && !wr_b && command == CMD_LOAD_B)
            ovf_next = 1'b1;
        if (state_reg == S_DONE && out_take)
        begin
            count_a_next   = '0;
            count_b_next   = '0;
            ovf_next       = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Vertex memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (wr_a)
            mem_a[count_a_reg[AW-1:0]] <= {x, y};
        if (wr_b)
            mem_b[count_b_reg[AW-1:0]] <= {x, y};
        qa_reg <= mem_a[rd_addr];
        qb_reg <= mem_b[rd_addr];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                dx_reg         <= 17'(x) - 17'(ref_x);
                dy_reg         <= 17'(y) - 17'(ref_y);
                phase_reg      <= 1'b0;
                edge_idx_reg   <= '0;
                have_reg       <= 1'b0;
                bx_reg         <= '0;
                by_reg         <= '0;
                blen_reg       <= '0;
                res_status_reg <= ovf_reg ? ST_OVERFLOW : ST_EMPTY;
            end
            S_EDGE_PREV:
            begin
                edge_idx_reg <= '0;
            end
            S_EDGE_LATCH:
            begin
                prev_x_reg <= edge_vx;
                prev_y_reg <= edge_vy;
            end
            S_EDGE_RD:
            begin
            end
            S_EDGE_NORM:
            begin
                nx_reg     <= 17'(prev_y_reg) - 17'(edge_vy);
                ny_reg     <= 17'(edge_vx) - 17'(prev_x_reg);
                prev_x_reg <= edge_vx;
                prev_y_reg <= edge_vy;
            end
            S_EDGE_SQ:
            begin
                sqx_reg <= nx_sq[31:0];
                sqy_reg <= ny_sq[31:0];
            end
            S_EDGE_LEN:
            begin
                len2_reg     <= len_sum;
                vtx_idx_reg  <= '0;
                span_sel_reg <= 1'b0;
                // skip a zero-length edge
                if (len_sum == '0)
                begin
                    edge_idx_reg <= edge_idx_reg + CW'(1);
                    if (edge_last)
                        phase_reg <= 1'b1;
                end
            end
            S_PROJ_RD:
            begin
            end
            S_PROJ_MUL:
            begin
                prod_x_reg <= nx_reg * span_vx;
                prod_y_reg <= ny_reg * span_vy;
            end
            S_PROJ_ACC:
            begin
                lo_reg      <= lo_new;
                hi_reg      <= hi_new;
                vtx_idx_reg <= vtx_idx_reg + CW'(1);
                if (vtx_last && !span_sel_reg)
                begin
                    a_lo_reg     <= lo_new;
                    a_hi_reg     <= hi_new;
                    span_sel_reg <= 1'b1;
                    vtx_idx_reg  <= '0;
                end
            end
            S_OVERLAP:
            begin
                d_reg        <= (ov1 < ov2) ? ov1 : ov2;
                comp_sel_reg <= 1'b0;
                if (separated)
                    res_status_reg <= ST_SEPARATED;
            end
            S_SCALE_LO:
            begin
                p_lo_reg <= comp_abs[15:0] * d_reg[17:0];
            end
            S_SCALE_HI:
            begin
                p_hi_reg <= comp_abs[15:0] * d_reg[34:18];
            end
            S_SCALE_NUM:
            begin
                rem_reg     <= {6'b0, num[50:24]};
                numlo_reg   <= {num[23:0], 8'b0};
                div_cnt_reg <= '0;
            end
            S_DIVIDE:
            begin
                rem_reg     <= q_bit ? trial_sub[32:0] : trial[32:0];
                numlo_reg   <= quo;
                div_cnt_reg <= div_cnt_reg + DW'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    comp_sel_reg <= 1'b1;
                    if (!comp_sel_reg)
                    begin
                        magx_reg <= quo[QMAG_W-1:0];
                        fx_reg   <= 49'($signed(quo_signed));
                    end
                    else
                    begin
                        magy_reg <= quo[QMAG_W-1:0];
                        fy_reg   <= 49'($signed(quo_signed));
                    end
                end
            end
            S_QLEN_SQ:
            begin
                sqqx_reg <= magx_reg * magx_reg;
                sqqy_reg <= magy_reg * magy_reg;
            end
            S_QLEN_SUM:
            begin
                // keep the strictly shorter candidate
                if (keep)
                begin
                    have_reg <= 1'b1;
                    bx_reg   <= fx_reg[PUSH_W-1:0];
                    by_reg   <= fy_reg[PUSH_W-1:0];
                    blen_reg <= ql;
                end
                edge_idx_reg <= edge_idx_reg + CW'(1);
                if (edge_last)
                    phase_reg <= 1'b1;
            end
            S_FLIP_MUL:
            begin
                fx_reg <= dx_reg * bx_reg;
                fy_reg <= dy_reg * by_reg;
            end
            S_FLIP:
            begin
                // point the push from B toward A
                if (flip_sum < 0)
                begin
                    bx_reg <= -bx_reg;
                    by_reg <= -by_reg;
                end
                res_status_reg <= ST_COLLIDING;
            end
            S_DONE:
            begin
                if (out_take)
                begin
                    status_reg <= res_status_reg;
                    push_x_reg <= (res_status_reg == ST_COLLIDING) ? bx_reg : '0;
                    push_y_reg <= (res_status_reg == ST_COLLIDING) ? by_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign push_x    = push_x_reg;
    assign push_y    = push_y_reg;

endmodule

// ===== hdl/psac_checker.sv =====
// Port-level checker of the polygon collision block, with its bind.
`include "polygon_separating_axis_collision_macros.svh"

module psac_port_checker
    import psac_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [1:0]                command,
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic signed [COORD_W-1:0] ref_x,
    input logic signed [COORD_W-1:0] ref_y,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [1:0]                status,
    input logic signed [PUSH_W-1:0]  push_x,
    input logic signed [PUSH_W-1:0]  push_y
);

    `PSAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(push_x) && $stable(push_y), "stalled result changed")
    `PSAC_ASSERT_NOW(a_push_zero, out_valid && status != ST_COLLIDING, push_x == 0 && push_y == 0, "push nonzero without collision")
    `PSAC_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && command == CMD_COMPUTE, !in_ready, "input taken right after compute")
    `PSAC_ASSERT_NEXT(a_load_one_cycle, in_valid && in_ready && (command == CMD_LOAD_A || command == CMD_LOAD_B), in_ready, "load did not finish in one cycle")

endmodule

bind polygon_separating_axis_collision psac_port_checker u_psac_port_checker (.*);
